// ===== hdl/msk_demodulator_pll_core_defines.svh =====
`ifndef MSK_DEMODULATOR_PLL_CORE_DEFINES_SVH
`define MSK_DEMODULATOR_PLL_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define MSK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define MSK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/msk_pkg.sv =====
`default_nettype none

package msk_pkg;

  localparam int TAPS_DEFAULT = 10;

  localparam logic [14:0] NCO_STEP_RESET  = 15'd9437;
  localparam logic [15:0] LOOP_GAIN_RESET = 16'd996;
  localparam logic [15:0] DC_COEFF_RESET  = 16'd1258;

  localparam logic signed [18:0] CLOCK_TURN3Q = 19'sd49152;
  localparam logic signed [18:0] CLOCK_FLOOR  = -19'sd131072;

  localparam logic [16:0] LOOP_DECAY = 17'd65503;
  localparam logic [16:0] LOOP_ZERO  = 17'd64555;

  localparam logic [16:0] SIN_A = 17'd102873;
  localparam logic [15:0] SIN_B = 16'd41906;
  localparam logic [12:0] SIN_C = 13'd4569;

  // floor(v/3) = (v * RECIP3) >> 17 for every 15-bit v.
  localparam logic [15:0] RECIP3 = 16'd43691;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // Cycles from issuing a phase to the sine unit until its result is visible.
  localparam int SINE_LAT = 4;

  // Arctangent quotient width; one quotient bit is resolved per divider step.
  localparam int QW = 15;

  typedef enum logic [1:0] {
    REG_NCO_STEP  = 2'd0,
    REG_LOOP_GAIN = 2'd1,
    REG_DC_COEFF  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    TAG_TAP = 2'd0,
    TAG_COS = 2'd1,
    TAG_SIN = 2'd2
  } sine_tag_t;

  typedef struct packed {
    logic        en;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic load_sample;
    logic do_step;
    logic tap_init;
    logic tap_issue;
    logic atan_setup;
    logic div_step;
    logic loop_mul;
    logic loop_upd;
    logic out_load;
    logic mix_cos;
    logic mix_sin;
    logic mix_mul;
    logic ring_write;
  } cmd_t;

  typedef struct packed {
    logic bit_event;
    logic mac_busy;
    logic sine_busy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/msk_sample_if.sv =====
`default_nettype none

interface msk_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/msk_result_if.sv =====
`default_nettype none

interface msk_result_if;
  logic               valid;
  logic               ready;
  logic               bit_value;
  logic signed [23:0] soft_value;

  modport source (output valid, output bit_value, output soft_value, input ready);
  modport sink (input valid, input bit_value, input soft_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/msk_cfg_if.sv =====
`default_nettype none

interface msk_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/msk_demodulator_pll_core.sv =====
// Channel   Direction  Contents
// samples   in         sample (16-bit signed audio sample)
// results   out        bit_value, soft_value (24-bit signed, saturated)
// cfg       in         index (0 nco_step, 1 loop_gain, 2 dc_coeff), data
//
// A sample without a bit clock event goes from stepping straight to mixing; one
// with an event first runs the filter, the arctangent and the loop update. The
// pace is set by the four-stage sine pipeline, the one-tap-per-cycle filter
// pass over the ring memory and the fifteen-step restoring divider.
// Reset is synchronous and active high; the rings read as zero until written.
// A result waits in the output register; the block stalls only when a second
// result is ready before the first has been taken.
`default_nettype none

`include "msk_demodulator_pll_core_defines.svh"

module msk_demodulator_pll_core
  import msk_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input wire logic      clk,
  input wire logic      rst,
  msk_sample_if.sink    samples,
  msk_result_if.source  results,
  msk_cfg_if.sink       cfg
);

  // Command and status buses between the sequencer and the arithmetic.
  cmd_t    cmd;
  stat_t   stat;
  cfg_wr_t cfg_wr;

  // Registers may be written at any time the block is idle, so the write
  // channel never pushes back.
  assign cfg.ready = 1'b1;

  always_comb begin
    cfg_wr.en    = cfg.valid;
    cfg_wr.index = cfg.index;
    cfg_wr.data  = cfg.data;
  end

  // The sequencer walks one sample through stepping, the optional filter and
  // loop update, and finally the mixing into the rings.
  msk_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_ready(samples.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // The datapath holds the oscillator, the bit clock, the loop filter, the
  // DC tracker, the rings and the output register.
  msk_dp #(.TAPS(TAPS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_wr   (cfg_wr),
    .sample_in(samples.sample),
    .out_ready(results.ready),
    .out_valid(results.valid),
    .out_bit  (results.bit_value),
    .out_soft (results.soft_value)
  );

  // Only one sample is in flight: acceptance closes the input until it is done.
  `MSK_ASSERT_NEXT(a_one_sample, clk, rst, samples.valid && samples.ready, !samples.ready, "second sample accepted while busy")
  // A waiting result is never overwritten.
  `MSK_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, !results.valid || results.ready, "result overwritten")
  // Writing the rings is the last step of a sample.
  `MSK_ASSERT_NEXT(a_write_ends, clk, rst, cmd.ring_write, samples.ready, "ring write did not end the request")

endmodule

`default_nettype wire

// ===== hdl/msk_ram.sv =====
`default_nettype none

module msk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/msk_sine.sv =====
`default_nettype none

module msk_sine
  import msk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               issue,
  input  wire sine_tag_t          tag_in,
  input  wire logic [15:0]        phase_in,
  output logic                    out_valid,
  output sine_tag_t               tag_out,
  output logic signed [15:0]      value,
  output logic                    busy
);

  // Quarter-wave odd polynomial t*(A - t^2*(B - t^2*C)), one product per stage.
  logic [14:0] t_c;
  logic [29:0] tt_c;
  logic [27:0] p2_c;
  logic [15:0] d3_c;
  logic [30:0] p3_c;
  logic [16:0] d4_c;
  logic [31:0] p4_c;
  logic [15:0] half_c;
  logic [14:0] mag_c;

  logic            s1_v, s2_v, s3_v, s4_v;
  sine_tag_t       s1_tag, s2_tag, s3_tag;
  logic            s1_neg, s2_neg, s3_neg;
  logic [14:0]     s1_t, s2_t, s3_t;
  logic [14:0]     s1_t2, s2_t2;
  logic [13:0]     s2_y1;
  logic [15:0]     s3_y2;

  assign t_c  = phase_in[14] ? (15'd16384 - {1'b0, phase_in[13:0]}) : {1'b0, phase_in[13:0]};
  assign tt_c = 30'(t_c) * 30'(t_c);
  assign p2_c = 28'(SIN_C) * 28'(s1_t2);
  assign d3_c = SIN_B - 16'(s2_y1);
  assign p3_c = 31'(d3_c) * 31'(s2_t2);
  assign d4_c = SIN_A - 17'(s3_y2);
  assign p4_c = 32'(d4_c) * 32'(s3_t);
  assign half_c = p4_c[30:15];
  assign mag_c  = (half_c > 16'd32767) ? 15'h7FFF : half_c[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    s1_tag <= tag_in;
    s1_neg <= phase_in[15];
    s1_t   <= t_c;
    s1_t2  <= tt_c[28:14];
    s2_tag <= s1_tag;
    s2_neg <= s1_neg;
    s2_t   <= s1_t;
    s2_t2  <= s1_t2;
    s2_y1  <= p2_c[27:14];
    s3_tag <= s2_tag;
    s3_neg <= s2_neg;
    s3_t   <= s2_t;
    s3_y2  <= p3_c[29:14];
    tag_out <= s3_tag;
    value   <= s3_neg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
  end

  assign out_valid = s4_v;
  assign busy      = s1_v | s2_v | s3_v | s4_v;

endmodule

`default_nettype wire

// ===== hdl/msk_ctrl.sv =====
`default_nettype none

module msk_ctrl
  import msk_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam int CNT_MAX = (TAPS - 1 > QW) ? TAPS - 1 : QW;
  localparam int CNT_W   = $clog2(CNT_MAX);
  localparam logic [CNT_W-1:0] TAP_LAST = CNT_W'(TAPS - 2);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_TAP_INIT, S_TAPS, S_DRAIN, S_ATAN, S_DIV,
    S_LOOP1, S_LOOP2, S_OUT, S_MIX_COS, S_MIX_SIN, S_MIX_WAIT, S_MIX_MUL, S_WRITE
  } state_t;

  state_t         state;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE:     if (in_valid) state <= S_STEP;
        S_STEP:     state <= stat.bit_event ? S_TAP_INIT : S_MIX_COS;
        S_TAP_INIT: begin
          cnt   <= '0;
          state <= S_TAPS;
        end
        S_TAPS: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == TAP_LAST) state <= S_DRAIN;
        end
        S_DRAIN:    if (!stat.mac_busy) state <= S_ATAN;
        S_ATAN: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == DIV_LAST) state <= S_LOOP1;
        end
        S_LOOP1:    state <= S_LOOP2;
        S_LOOP2:    state <= S_OUT;
        S_OUT:      if (stat.out_free) state <= S_MIX_COS;
        S_MIX_COS:  state <= S_MIX_SIN;
        S_MIX_SIN:  state <= S_MIX_WAIT;
        S_MIX_WAIT: if (!stat.sine_busy) state <= S_MIX_MUL;
        S_MIX_MUL:  state <= S_WRITE;
        S_WRITE:    state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.load_sample = (state == S_IDLE) && in_valid;
    cmd.do_step     = (state == S_STEP);
    cmd.tap_init    = (state == S_TAP_INIT);
    cmd.tap_issue   = (state == S_TAPS);
    cmd.atan_setup  = (state == S_ATAN);
    cmd.div_step    = (state == S_DIV);
    cmd.loop_mul    = (state == S_LOOP1);
    cmd.loop_upd    = (state == S_LOOP2);
    cmd.out_load    = (state == S_OUT) && stat.out_free;
    cmd.mix_cos     = (state == S_MIX_COS);
    cmd.mix_sin     = (state == S_MIX_SIN);
    cmd.mix_mul     = (state == S_MIX_MUL);
    cmd.ring_write  = (state == S_WRITE);
  end

endmodule

`default_nettype wire

// ===== hdl/msk_dp.sv =====
`default_nettype none

module msk_dp
  import msk_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire cfg_wr_t            cfg_wr,
  input  wire logic signed [15:0] sample_in,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_bit,
  output logic signed [23:0]      out_soft
);

  localparam int IDX_W = $clog2(TAPS);
  localparam int ACC_W = 40 + $clog2(TAPS);
  localparam int IV_W  = ACC_W - 18;
  localparam int NUM_W = IV_W + 14;
  localparam int DSH_W = IV_W + 15;
  localparam int DLY   = SINE_LAT - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    else if (v < -64'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Configuration and loop state.
  logic [14:0]        nco_step;
  logic [15:0]        loop_gain;
  logic [15:0]        dc_coeff;
  logic [15:0]        carrier_phase;
  logic signed [17:0] bit_clock;
  logic signed [23:0] freq_offset;
  logic signed [23:0] last_error;
  logic signed [31:0] dc_level;
  logic [1:0]         quadrant;
  logic [IDX_W-1:0]   ring_idx;
  logic [TAPS-1:0]    ring_valid;

  logic signed [15:0] sample_q;
  logic signed [32:0] s16;

  // Step and bit clock.
  logic signed [15:0] fo_sh;
  logic signed [17:0] step;
  logic signed [18:0] clk_sum, clk_sat, clk_new;
  logic               bit_event;

  assign fo_sh   = freq_offset[23:8];
  assign step    = $signed({3'b000, nco_step}) + $signed({{2{fo_sh[15]}}, fo_sh});
  assign clk_sum = $signed({bit_clock[17], bit_clock}) + $signed({step[17], step});
  assign clk_sat = (clk_sum < CLOCK_FLOOR) ? CLOCK_FLOOR : clk_sum;
  assign bit_event = clk_sat > CLOCK_TURN3Q;
  assign clk_new = bit_event ? (clk_sat - CLOCK_TURN3Q) : clk_sat;

  // Tap phase generator: floor((j+1)*nco_step/3) kept as quotient and remainder.
  logic [30:0] prod3;
  logic [14:0] r15;
  logic [13:0] step3;
  logic [1:0]  step_rem;
  logic [15:0] tap_ph;
  logic [1:0]  tap_rem;
  logic [2:0]  rem_sum;
  logic        rem_carry;
  logic [IDX_W-1:0] rd_ptr;

  assign prod3     = 31'(nco_step) * 31'(RECIP3);
  assign r15       = nco_step - 15'(15'(prod3[30:17]) * 15'd3);
  assign rem_sum   = {1'b0, tap_rem} + {1'b0, step_rem};
  assign rem_carry = rem_sum >= 3'd3;

  // Sine unit.
  logic               sn_issue;
  sine_tag_t          sn_tag_in, sn_tag_out;
  logic [15:0]        sn_phase;
  logic               sn_valid, sn_busy;
  logic signed [15:0] sn_value;

  always_comb begin
    sn_issue  = cmd.tap_issue | cmd.mix_cos | cmd.mix_sin;
    sn_tag_in = TAG_TAP;
    sn_phase  = tap_ph;
    if (cmd.mix_cos) begin
      sn_tag_in = TAG_COS;
      sn_phase  = carrier_phase + QUARTER_TURN;
    end else if (cmd.mix_sin) begin
      sn_tag_in = TAG_SIN;
      sn_phase  = carrier_phase;
    end
  end

  msk_sine u_sine (
    .clk      (clk),
    .rst      (rst),
    .issue    (sn_issue),
    .tag_in   (sn_tag_in),
    .phase_in (sn_phase),
    .out_valid(sn_valid),
    .tag_out  (sn_tag_out),
    .value    (sn_value),
    .busy     (sn_busy)
  );

  // Ring store, I in the upper half and Q in the lower half.
  logic        ram_we;
  logic [47:0] ram_wdata, ram_rdata;
  logic        rd_valid;
  logic [47:0] dly [DLY];

  msk_ram #(.WIDTH(48), .DEPTH(TAPS)) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ring_idx),
    .wdata(ram_wdata),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // Matched filter.
  logic signed [23:0]      ri, rq;
  logic signed [39:0]      prod_i, prod_q;
  logic                    prod_v;
  logic signed [ACC_W-1:0] acc_i, acc_q;

  assign ri = dly[DLY-1][47:24];
  assign rq = dly[DLY-1][23:0];

  // Arctangent argument selection. The chosen x is never negative.
  logic signed [IV_W-1:0] iv, qv;
  logic signed [IV_W:0]   iv_e, qv_e, y_s, x_s, dec_c, ay_s;
  logic [IV_W-1:0]        ay, ax;
  logic [IV_W:0]          den;

  assign iv   = acc_i[ACC_W-1:18];
  assign qv   = acc_q[ACC_W-1:18];
  assign iv_e = $signed({iv[IV_W-1], iv});
  assign qv_e = $signed({qv[IV_W-1], qv});

  always_comb begin
    if (!quadrant[0]) begin
      y_s   = iv_e[IV_W] ? qv_e : -qv_e;
      x_s   = iv_e[IV_W] ? -iv_e : iv_e;
      dec_c = quadrant[1] ? iv_e : -iv_e;
    end else begin
      y_s   = qv_e[IV_W] ? -iv_e : iv_e;
      x_s   = qv_e[IV_W] ? -qv_e : qv_e;
      dec_c = quadrant[1] ? -qv_e : qv_e;
    end
  end

  assign ay_s = y_s[IV_W] ? -y_s : y_s;
  assign ay   = ay_s[IV_W-1:0];
  assign ax   = x_s[IV_W-1:0];
  assign den  = {1'b0, ay} + {1'b0, ax};

  // Restoring divider, one quotient bit per step.
  logic [NUM_W-1:0]     div_rem;
  logic [DSH_W-1:0]     div_dsh;
  logic [QW-1:0]        quo;
  logic                 err_neg, err_zero;
  logic signed [IV_W:0] dec_q;
  logic [DSH_W-1:0]     div_diff;
  logic                 div_ge;

  assign div_diff = {1'b0, div_rem} - div_dsh;
  assign div_ge   = {1'b0, div_rem} >= div_dsh;

  // Loop filter.
  logic signed [16:0] err;
  logic signed [33:0] perr;
  logic signed [41:0] pfo, ple;
  logic signed [23:0] dphi, soft_sat;

  assign err  = err_zero ? 17'sd0 :
                (err_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));
  assign dphi = sat24(64'($signed(perr[33:8])));
  assign soft_sat = sat24(64'(dec_q));

  // Mixing and DC tracking.
  logic signed [15:0] cosv, sinv;
  logic signed [49:0] dc_prod;
  logic signed [48:0] pic, pqs;
  logic signed [23:0] ri_new, rq_new;
  logic               res_bit;
  logic signed [23:0] res_soft;

  assign ri_new    = sat24(64'($signed(pic[48:24])));
  assign rq_new    = sat24(64'($signed(pqs[48:24])));
  assign ram_we    = cmd.ring_write;
  assign ram_wdata = {ri_new, rq_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      nco_step      <= NCO_STEP_RESET;
      loop_gain     <= LOOP_GAIN_RESET;
      dc_coeff      <= DC_COEFF_RESET;
      carrier_phase <= '0;
      bit_clock     <= '0;
      freq_offset   <= '0;
      last_error    <= '0;
      dc_level      <= '0;
      quadrant      <= '0;
      ring_idx      <= '0;
      ring_valid    <= '0;
      prod_v        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr.en) begin
        case (cfg_wr.index)
          REG_NCO_STEP:  nco_step  <= cfg_wr.data[14:0];
          REG_LOOP_GAIN: loop_gain <= cfg_wr.data;
          REG_DC_COEFF:  dc_coeff  <= cfg_wr.data;
          default:       ;
        endcase
      end
      if (cmd.do_step) begin
        carrier_phase <= carrier_phase + step[15:0];
        bit_clock     <= clk_new[17:0];
      end
      prod_v <= sn_valid && (sn_tag_out == TAG_TAP);
      if (cmd.loop_upd) begin
        freq_offset <= sat24(64'($signed(pfo[41:16])) + 64'(dphi) - 64'($signed(ple[41:16])));
        last_error  <= dphi;
        quadrant    <= quadrant + 2'd1;
      end
      if (cmd.mix_mul) begin
        dc_level <= sat32(64'(dc_level) + 64'($signed(dc_prod[49:16])));
      end
      if (cmd.ring_write) begin
        ring_valid[ring_idx] <= 1'b1;
        ring_idx <= (ring_idx == LAST_IDX) ? '0 : ring_idx + IDX_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    step3    <= prod3[30:17];
    step_rem <= r15[1:0];

    if (cmd.load_sample) sample_q <= sample_in;
    if (cmd.do_step) begin
      s16 <= $signed({sample_q[15], sample_q, 16'd0}) - $signed({dc_level[31], dc_level});
    end

    if (cmd.tap_init) begin
      tap_ph  <= 16'(step3);
      tap_rem <= step_rem;
      rd_ptr  <= (ring_idx == LAST_IDX) ? '0 : ring_idx + IDX_W'(1);
      acc_i   <= '0;
      acc_q   <= '0;
    end else begin
      if (cmd.tap_issue) begin
        tap_ph  <= tap_ph + 16'(step3) + (rem_carry ? 16'd1 : 16'd0);
        tap_rem <= rem_carry ? 2'(rem_sum - 3'd3) : rem_sum[1:0];
        rd_ptr  <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (prod_v) begin
        acc_i <= acc_i + $signed({{(ACC_W-40){prod_i[39]}}, prod_i});
        acc_q <= acc_q + $signed({{(ACC_W-40){prod_q[39]}}, prod_q});
      end
    end

    rd_valid <= ring_valid[rd_ptr];
    dly[0]   <= rd_valid ? ram_rdata : 48'd0;
    for (int k = 1; k < DLY; k++) dly[k] <= dly[k-1];

    prod_i <= 40'(sn_value) * 40'(ri);
    prod_q <= 40'(sn_value) * 40'(rq);

    if (sn_valid && (sn_tag_out == TAG_COS)) cosv <= sn_value;
    if (sn_valid && (sn_tag_out == TAG_SIN)) sinv <= sn_value;

    if (cmd.atan_setup) begin
      div_rem  <= {ay, 14'd0};
      div_dsh  <= {den, 14'd0};
      quo      <= '0;
      err_neg  <= y_s[IV_W];
      err_zero <= (den == '0);
      dec_q    <= dec_c;
    end else if (cmd.div_step) begin
      if (div_ge) div_rem <= div_diff[NUM_W-1:0];
      div_dsh <= div_dsh >> 1;
      quo     <= {quo[QW-2:0], div_ge};
    end

    if (cmd.loop_mul) begin
      perr <= 34'(err) * 34'($signed({1'b0, loop_gain}));
      pfo  <= 42'(freq_offset) * 42'($signed({1'b0, LOOP_DECAY}));
      ple  <= 42'(last_error) * 42'($signed({1'b0, LOOP_ZERO}));
    end
    if (cmd.loop_upd) begin
      res_soft <= soft_sat;
      res_bit  <= (soft_sat > 24'sd0);
    end
    if (cmd.out_load) begin
      out_bit  <= res_bit;
      out_soft <= res_soft;
    end

    if (cmd.mix_cos) dc_prod <= 50'(s16) * 50'($signed({1'b0, dc_coeff}));
    if (cmd.mix_mul) begin
      pic <= 49'(s16) * 49'(cosv);
      pqs <= 49'(s16) * 49'(sinv);
    end
  end

  always_comb begin
    stat.bit_event = bit_event;
    stat.mac_busy  = sn_busy | prod_v;
    stat.sine_busy = sn_busy;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire
